[hdl/pidwi_pkg.sv]
`timescale 1ns / 1ps

package pidwi_pkg;

    localparam int DATA_W     = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic signed [DATA_W:0]   t_diff;
    typedef logic [REG_IDX_W-1:0]     t_reg_idx;

    // register index = paddr[3:2]
    localparam t_reg_idx REG_GAIN_P       = 2'd0;
    localparam t_reg_idx REG_GAIN_I       = 2'd1;
    localparam t_reg_idx REG_GAIN_D       = 2'd2;
    localparam t_reg_idx REG_MAX_THROTTLE = 2'd3;

    typedef struct packed {
        t_sample gain_p;
        t_sample gain_i;
        t_sample gain_d;
        t_sample max_throttle;
    } t_cfg;

    // request leaving the window stage
    typedef struct packed {
        logic    valid;
        t_sample e;
        t_diff   diff;
    } t_stage1;

endpackage

[hdl/pidwi_in_if.sv]
`timescale 1ns / 1ps

interface pidwi_in_if;
    logic               valid;
    logic               ready;
    pidwi_pkg::t_sample error_sample;

    modport source (output valid, output error_sample, input ready);
    modport sink (input valid, input error_sample, output ready);
endinterface

[hdl/pidwi_out_if.sv]
`timescale 1ns / 1ps

interface pidwi_out_if;
    logic               valid;
    logic               ready;
    pidwi_pkg::t_sample control_value;
    pidwi_pkg::t_sample throttle_value;
    logic               control_saturated;
    logic               throttle_saturated;

    modport source (
        output valid, output control_value, output throttle_value,
        output control_saturated, output throttle_saturated, input ready
    );
    modport sink (
        input valid, input control_value, input throttle_value,
        input control_saturated, input throttle_saturated, output ready
    );
endinterface

[hdl/pidwi_regs.sv]
`timescale 1ns / 1ps

module pidwi_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pidwi_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pidwi_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pidwi_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output pidwi_pkg::t_cfg                     o_cfg
);

    pidwi_pkg::t_cfg      r_cfg;
    pidwi_pkg::t_reg_idx  w_idx;
    pidwi_pkg::t_sample   w_wdata;
    pidwi_pkg::t_sample   w_rdata;
    logic                 w_write;

    assign pready  = 1'b1;
    assign w_idx   = paddr[pidwi_pkg::APB_ADDR_W-1:2];
    assign w_wdata = pwdata[pidwi_pkg::DATA_W-1:0];
    assign w_write = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_write) begin
            case (w_idx)
                pidwi_pkg::REG_GAIN_P:       r_cfg.gain_p       <= w_wdata;
                pidwi_pkg::REG_GAIN_I:       r_cfg.gain_i       <= w_wdata;
                pidwi_pkg::REG_GAIN_D:       r_cfg.gain_d       <= w_wdata;
                pidwi_pkg::REG_MAX_THROTTLE: r_cfg.max_throttle <= w_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            pidwi_pkg::REG_GAIN_P:       w_rdata = r_cfg.gain_p;
            pidwi_pkg::REG_GAIN_I:       w_rdata = r_cfg.gain_i;
            pidwi_pkg::REG_GAIN_D:       w_rdata = r_cfg.gain_d;
            pidwi_pkg::REG_MAX_THROTTLE: w_rdata = r_cfg.max_throttle;
            default:                     w_rdata = '0;
        endcase
    end

    assign prdata = {{(pidwi_pkg::APB_DATA_W - pidwi_pkg::DATA_W){1'b0}}, w_rdata};
    assign o_cfg  = r_cfg;

endmodule

[hdl/pidwi_window.sv]
`timescale 1ns / 1ps

module pidwi_window #(
    parameter int WINDOW_DEPTH = 8,
    parameter int SUM_W        = pidwi_pkg::DATA_W + $clog2(WINDOW_DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic                    i_adv,
    input  pidwi_pkg::t_sample      i_sample,
    output pidwi_pkg::t_stage1      o_s1,
    output logic signed [SUM_W-1:0] o_sum
);

    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    pidwi_pkg::t_sample r_mem [WINDOW_DEPTH];
    pidwi_pkg::t_sample r_old;
    logic [PTR_W-1:0]   r_ptr;
    logic               r_full;
    logic               r_s1_full;
    logic               r_s1_valid;
    pidwi_pkg::t_sample r_s1_e;
    pidwi_pkg::t_diff   r_s1_diff;
    pidwi_pkg::t_sample r_prev;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] w_old_ext;

    // read-first ring: the read returns the entry being replaced
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_mem[r_ptr] <= i_sample;
            r_old        <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_s1_e    <= i_sample;
            r_s1_diff <= pidwi_pkg::t_diff'(i_sample) - pidwi_pkg::t_diff'(r_prev);
        end
    end

    // slots not yet written since reset count as zero
    assign w_old_ext = r_s1_full ? SUM_W'(r_old) : '0;
    assign n_sum     = r_sum + SUM_W'(r_s1_e) - w_old_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_full     <= 1'b0;
            r_s1_full  <= 1'b0;
            r_s1_valid <= 1'b0;
            r_prev     <= '0;
            r_sum      <= '0;
        end else begin
            if (i_fire) begin
                r_prev    <= i_sample;
                r_s1_full <= r_full;
                if (r_ptr == PTR_W'(WINDOW_DEPTH - 1)) begin
                    r_ptr  <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            if (i_adv) begin
                r_s1_valid <= i_fire;
                if (r_s1_valid) begin
                    r_sum <= n_sum;
                end
            end
        end
    end

    assign o_s1.valid = r_s1_valid;
    assign o_s1.e     = r_s1_e;
    assign o_s1.diff  = r_s1_diff;
    // window sum including the request held in the input register
    assign o_sum      = n_sum;

endmodule

[hdl/pidwi_calc.sv]
`timescale 1ns / 1ps

module pidwi_calc #(
    parameter int GAIN_FRACTION_BITS = 8,
    parameter int SUM_W              = 19
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pidwi_pkg::t_cfg         i_cfg,
    input  pidwi_pkg::t_stage1      i_s1,
    input  logic signed [SUM_W-1:0] i_sum,
    output logic                    o_adv,
    pidwi_out_if.source             o_result
);

    localparam int P_W   = 2 * pidwi_pkg::DATA_W;
    localparam int D_W   = 2 * pidwi_pkg::DATA_W + 1;
    localparam int I_W   = pidwi_pkg::DATA_W + SUM_W;
    localparam int ACC_W = ((I_W > D_W) ? I_W : D_W) + 3;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

    logic                    w_adv;
    logic signed [P_W-1:0]   w_p_prod;
    logic signed [D_W-1:0]   w_d_prod;
    logic signed [I_W-1:0]   w_i_prod;
    logic signed [ACC_W-1:0] w_p;
    logic signed [ACC_W-1:0] w_d;
    logic signed [ACC_W-1:0] w_i;
    logic signed [ACC_W-1:0] w_pid;
    logic signed [ACC_W-1:0] w_thr;
    pidwi_pkg::t_sample      n_ctrl;
    pidwi_pkg::t_sample      n_thr;
    logic                    n_ctrl_sat;
    logic                    n_thr_sat;
    logic                    r_out_valid;
    pidwi_pkg::t_sample      r_ctrl;
    pidwi_pkg::t_sample      r_thr;
    logic                    r_ctrl_sat;
    logic                    r_thr_sat;

    // input and result registers move together; only a waiting result can hold them
    assign w_adv = !r_out_valid || o_result.ready;
    assign o_adv = w_adv;

    assign w_p_prod = P_W'(i_cfg.gain_p) * P_W'(i_s1.e);
    assign w_d_prod = D_W'(i_cfg.gain_d) * D_W'(i_s1.diff);
    assign w_i_prod = I_W'(i_cfg.gain_i) * I_W'(i_sum);

    // arithmetic shift gives floor rounding
    assign w_p   = ACC_W'(w_p_prod) >>> GAIN_FRACTION_BITS;
    assign w_d   = ACC_W'(w_d_prod) >>> GAIN_FRACTION_BITS;
    assign w_i   = ACC_W'(w_i_prod) >>> GAIN_FRACTION_BITS;
    assign w_pid = w_p + w_i + w_d;
    assign w_thr = ACC_W'(i_cfg.max_throttle) - w_pid;

    always_comb begin
        if (w_pid > SAT_HI) begin
            n_ctrl     = SAT_HI[pidwi_pkg::DATA_W-1:0];
            n_ctrl_sat = 1'b1;
        end else if (w_pid < SAT_LO) begin
            n_ctrl     = SAT_LO[pidwi_pkg::DATA_W-1:0];
            n_ctrl_sat = 1'b1;
        end else begin
            n_ctrl     = w_pid[pidwi_pkg::DATA_W-1:0];
            n_ctrl_sat = 1'b0;
        end
        if (w_thr > SAT_HI) begin
            n_thr     = SAT_HI[pidwi_pkg::DATA_W-1:0];
            n_thr_sat = 1'b1;
        end else if (w_thr < SAT_LO) begin
            n_thr     = SAT_LO[pidwi_pkg::DATA_W-1:0];
            n_thr_sat = 1'b1;
        end else begin
            n_thr     = w_thr[pidwi_pkg::DATA_W-1:0];
            n_thr_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ctrl     <= n_ctrl;
            r_thr      <= n_thr;
            r_ctrl_sat <= n_ctrl_sat;
            r_thr_sat  <= n_thr_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= i_s1.valid;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.control_value      = r_ctrl;
    assign o_result.throttle_value     = r_thr;
    assign o_result.control_saturated  = r_ctrl_sat;
    assign o_result.throttle_saturated = r_thr_sat;

endmodule

[hdl/pid_windowed_integral.sv]
`timescale 1ns / 1ps
// channel    dir  handshake             payload
// i_sample   in   valid/ready           error_sample
// o_result   out  valid/ready           control_value, throttle_value, *_saturated
// apb        in   psel/penable, pready  paddr, pwdata -> prdata
//
// one request accepted per cycle unless a result waits untaken; it is held in the
// input register and the result register loads from it (window sum, three multiplies,
// sum and saturate); the result is offered from the result register
// synchronous active-low reset clears pointer, window fill flag, sum, previous
// error, gains and valids; no clearing pass, unwritten window slots read as zero
// a result not taken holds the result register, the input register and the input

module pid_windowed_integral #(
    parameter int WINDOW_DEPTH       = 8,
    parameter int GAIN_FRACTION_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pidwi_in_if.sink                         i_sample,
    pidwi_out_if.source                      o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pidwi_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pidwi_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pidwi_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);

    localparam int SUM_W = pidwi_pkg::DATA_W + $clog2(WINDOW_DEPTH);

    pidwi_pkg::t_cfg         w_cfg;
    pidwi_pkg::t_stage1      w_s1;
    logic signed [SUM_W-1:0] w_sum;
    logic                    w_adv;
    logic                    w_fire;

    assign i_sample.ready = w_adv;
    assign w_fire         = i_sample.valid & w_adv;

    pidwi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pidwi_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SUM_W        (SUM_W)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_adv    (w_adv),
        .i_sample (i_sample.error_sample),
        .o_s1     (w_s1),
        .o_sum    (w_sum)
    );

    pidwi_calc #(
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS),
        .SUM_W              (SUM_W)
    ) u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_s1     (w_s1),
        .i_sum    (w_sum),
        .o_adv    (w_adv),
        .o_result (o_result)
    );

endmodule
